### rtl/mwcsd_pkg.sv
// Package: types and constants for the MW cycle slip detector.
package mwcsd_pkg;

  localparam int unsigned Channels   = 256;
  localparam int unsigned ChanWidth  = $clog2(Channels);
  localparam int unsigned CountWidth = 16;

  localparam logic [0:0] RegMaxGap    = 1'd0;
  localparam logic [0:0] RegMinCycles = 1'd1;

  typedef struct packed {
    logic [7:0]         channel;
    logic [39:0]        epoch_time_ms;
    logic signed [47:0] mw_value;
    logic signed [23:0] wavelength;
    logic [31:0]        initial_variance;
  } mwcsd_in_t;

  typedef struct packed {
    logic [7:0] channel_out;
    logic       slip_flag;
  } mwcsd_out_t;

  // One channel entry as held in the state memory.
  typedef struct packed {
    logic signed [47:0]    mean;
    logic [31:0]           variance;
    logic [CountWidth-1:0] count;
    logic [39:0]           last_time;
  } mwcsd_entry_t;

endpackage

### rtl/mw_cycle_slip_detector_unit.sv
// Top level: MW cycle slip detector with per-channel state memory and serial divider.
//
// An item is taken when start_i is high and busy_o is low. An item that continues a
// channel keeps busy_o high through a memory read, a judge step, a restoring divider
// that divides bias and the variance step by the window count in parallel, a
// write-back and the result cycle. The next item can be taken at the end of the idle
// cycle that follows. An item that restarts its channel (a slip, or a channel never
// seen) skips the divider; a channel at or above Channels goes from the read straight
// to the result cycle. The result (channel_out, slip_flag) is shown with done_o for
// one cycle and cannot be held off. busy_o stays high until then. No clearing pass
// is needed after reset: a seen bit per channel is held in flip-flops.
module mw_cycle_slip_detector_unit
  import mwcsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  mwcsd_in_t  item_i,
  output logic       done_o,
  output mwcsd_out_t result_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StJudge = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StWrite = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  localparam int unsigned DivW = 51;
  localparam logic [CountWidth-1:0] CountMax = '1;

  logic [2:0]    state_q, state_d;
  mwcsd_in_t     in_q;
  logic [31:0]   max_gap_q;
  logic [15:0]   min_cycles_q;
  logic [Channels-1:0] seen_q;
  logic          slip_q;
  logic          in_range_q;
  logic [5:0]    cnt_q;

  mwcsd_entry_t  mem [Channels];
  mwcsd_entry_t  rd_q;
  mwcsd_entry_t  wr_d;

  // Divider operands: magnitudes, signs, remainders and quotients.
  logic [DivW-1:0]       num_m_q, num_v_q;
  logic [DivW-1:0]       rem_m_q, rem_v_q;
  logic                  neg_m_q, neg_v_q;
  logic [CountWidth-1:0] div_q;

  logic [ChanWidth-1:0] ch_idx;
  assign ch_idx = in_q.channel[ChanWidth-1:0];

  // Judge logic on the read entry.
  logic signed [48:0] bias;
  logic [48:0] ab;
  logic [23:0] awl;
  logic [39:0] lim;
  logic [97:0] ab2;
  logic [39:0] gap;
  logic        slip_c;
  logic [CountWidth-1:0] cnt_n;
  logic signed [50:0] vstep;

  always_comb begin
    bias  = 49'(in_q.mw_value) - 49'(rd_q.mean);
    ab    = bias[48] ? 49'(-bias) : 49'(bias);
    awl   = in_q.wavelength[23] ? 24'(-in_q.wavelength) : 24'(in_q.wavelength);
    lim   = 40'(min_cycles_q) * 40'(awl);
    ab2   = 98'(ab[23:0]) * 98'(ab[23:0]);
    gap   = in_q.epoch_time_ms - rd_q.last_time;
    slip_c = !seen_q[ch_idx];
    if (in_q.epoch_time_ms > rd_q.last_time && gap > 40'(max_gap_q)) slip_c = 1'b1;
    if ({ab, 8'd0} > 57'(lim)) slip_c = 1'b1;
    if (ab >= 49'(1 << 23)) slip_c = 1'b1;
    else if (ab2 > 98'({rd_q.variance, 12'd0})) slip_c = 1'b1;
    cnt_n = (rd_q.count != CountMax) ? rd_q.count + 1'b1 : rd_q.count;
    if (cnt_n == '0) cnt_n = {{(CountWidth-1){1'b0}}, 1'b1};
    vstep = 51'(ab2[55:8]) - 51'(rd_q.variance);
  end

  // Shift-subtract step of both dividers.
  logic [DivW:0] tm, tv;
  assign tm = {rem_m_q, num_m_q[DivW-1]} - (DivW+1)'(div_q);
  assign tv = {rem_v_q, num_v_q[DivW-1]} - (DivW+1)'(div_q);

  // Write-back entry.
  logic signed [48:0] qm;
  logic signed [51:0] nv;
  always_comb begin
    qm = neg_m_q ? -49'(num_m_q) : 49'(num_m_q);
    nv = 52'(rd_q.variance) + (neg_v_q ? -52'(num_v_q) : 52'(num_v_q));
    wr_d.last_time = in_q.epoch_time_ms;
    if (slip_q) begin
      wr_d.mean     = in_q.mw_value;
      wr_d.variance = in_q.initial_variance;
      wr_d.count    = {{(CountWidth-1){1'b0}}, 1'b1};
    end else begin
      wr_d.mean     = 48'(49'(rd_q.mean) + qm);
      wr_d.variance = nv[51] ? 32'd0 : (nv[50:32] != '0 ? 32'hFFFF_FFFF : nv[31:0]);
      wr_d.count    = div_q;
    end
  end

  // Read and write the state memory.
  always_ff @(posedge clk_i) begin
    if (state_q == StRead) rd_q <= mem[ch_idx];
    if (state_q == StWrite) mem[ch_idx] <= wr_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (start_i) state_d = StRead;
      StRead:  state_d = in_range_q ? StJudge : StDone;
      StJudge: state_d = slip_c ? StWrite : StDiv;
      StDiv:   if (cnt_q == 6'(DivW-1)) state_d = StWrite;
      StWrite: state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      max_gap_q    <= 32'd61000;
      min_cycles_q <= 16'd512;
      seen_q       <= '0;
      cnt_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == RegMaxGap)    max_gap_q    <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == RegMinCycles) min_cycles_q <= cfg_wdata_i[15:0];
      if (state_q == StWrite) seen_q[ch_idx] <= 1'b1;
      cnt_q <= (state_q == StDiv) ? cnt_q + 6'd1 : 6'd0;
    end
  end

  // Payload and divider datapath.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      in_q       <= item_i;
      in_range_q <= (32'(item_i.channel) < Channels);
      slip_q     <= 1'b0;
    end
    if (state_q == StJudge) begin
      slip_q  <= slip_c;
      div_q   <= cnt_n;
      num_m_q <= DivW'(ab);
      neg_m_q <= bias[48];
      num_v_q <= vstep[50] ? DivW'(-vstep) : DivW'(vstep);
      neg_v_q <= vstep[50];
      rem_m_q <= '0;
      rem_v_q <= '0;
    end
    if (state_q == StDiv) begin
      if (!tm[DivW]) begin
        rem_m_q <= tm[DivW-1:0];
        num_m_q <= {num_m_q[DivW-2:0], 1'b1};
      end else begin
        rem_m_q <= {rem_m_q[DivW-2:0], num_m_q[DivW-1]};
        num_m_q <= {num_m_q[DivW-2:0], 1'b0};
      end
      if (!tv[DivW]) begin
        rem_v_q <= tv[DivW-1:0];
        num_v_q <= {num_v_q[DivW-2:0], 1'b1};
      end else begin
        rem_v_q <= {rem_v_q[DivW-2:0], num_v_q[DivW-1]};
        num_v_q <= {num_v_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign busy_o               = (state_q != StIdle);
  assign done_o               = (state_q == StDone);
  assign result_o.channel_out = in_q.channel;
  assign result_o.slip_flag   = slip_q;

  // A result follows only a write or an out-of-range read.
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == StWrite || $past(state_q) == StRead))
    else $error("done without source");
  // An unseen channel always reports a slip.
  a_unseen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StJudge && !seen_q[ch_idx]) |=> slip_q)
    else $error("unseen channel without slip");
  // Busy is raised when an item is taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && start_i) |=> busy_o)
    else $error("start not taken");

endmodule
